### rtl/smalu_pkg.sv
// Package: command codes, controller states and control structs for the stack calculator
package smalu_pkg;
	localparam int unsigned ValW = 31;
	localparam logic signed [ValW-1:0] MagLimit = 31'sd1000000000;

	typedef enum logic [3:0] {
		CMD_START = 4'd0, CMD_NUM = 4'd1, CMD_POP = 4'd2, CMD_INV = 4'd3,
		CMD_DUP = 4'd4, CMD_SWP = 4'd5, CMD_ADD = 4'd6, CMD_SUB = 4'd7,
		CMD_MUL = 4'd8, CMD_DIV = 4'd9, CMD_MOD = 4'd10, CMD_END = 4'd11
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD1, ST_RD2, ST_EXEC, ST_MUL, ST_DIV, ST_WR, ST_WR2, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		WR_NONE, WR_PUSH_OPND, WR_RES_TOP, WR_RES_BELOW, WR_A_TOP, WR_PUSH_TOP
	} wr_sel_t;

	typedef struct packed {
		logic   load;      // latch request
		logic   rd_top;    // read entry count-1
		logic   rd_sec;    // read entry count-2
		logic   cap_top;   // capture read data as top
		logic   cap_sec;   // capture read data as second
		logic   mul_go;
		logic   div_go;
		logic   div_step;
		wr_sel_t wr;
	} ctl_t;

	typedef struct packed {
		logic div_done;
		logic div_zero;
	} sts_t;
endpackage

### rtl/smalu_if.sv
// Valid/ready channel interfaces for the stack calculator
interface smalu_in_if;
	logic                     valid;
	logic                     ready;
	logic [3:0]               cmd;
	logic signed [30:0]       operand;
	modport source (output valid, cmd, operand, input ready);
	modport sink (input valid, cmd, operand, output ready);
endinterface

interface smalu_out_if;
	logic                     valid;
	logic                     ready;
	logic signed [30:0]       value;
	logic                     error;
	modport source (output valid, value, error, input ready);
	modport sink (input valid, value, error, output ready);
endinterface

### rtl/smalu_ctrl.sv
// Controller: sequences one instruction through stack reads, arithmetic and write-back
module smalu_ctrl #(
	parameter int unsigned CntW = 11,
	parameter int unsigned Depth = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0]           in_cmd,
	input  logic                 opnd_big,
	input  smalu_pkg::sts_t      sts,
	input  logic                 res_big,
	output smalu_pkg::ctl_t      ctl,
	output logic [CntW-1:0]      count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_err
);
	smalu_pkg::state_t state_q, state_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic err_q, err_d;
	logic [3:0] cmd_q;
	logic oerr_q, oerr_d;
	logic acc;
	logic full;

	assign acc = in_valid && in_ready;
	assign count = cnt_q;
	assign full = (cnt_q == CntW'(Depth));
	assign out_err = oerr_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		err_d = err_q;
		oerr_d = oerr_q;
		case (state_q)
			smalu_pkg::ST_IDLE: begin
				if (acc) begin
					if (in_cmd == smalu_pkg::CMD_END) begin
						oerr_d = err_q || (cnt_q != CntW'(1));
						state_d = smalu_pkg::ST_OUT;
					end else if (!err_q && in_cmd < smalu_pkg::CMD_END) begin
						case (smalu_pkg::cmd_t'(in_cmd))
							smalu_pkg::CMD_START: begin
								if (opnd_big) begin
									err_d = 1'b1;
								end else begin
									cnt_d = CntW'(1);
								end
							end
							smalu_pkg::CMD_NUM: begin
								if (opnd_big || full) begin
									err_d = 1'b1;
								end else begin
									cnt_d = cnt_q + 1'b1;
								end
							end
							smalu_pkg::CMD_POP: begin
								if (cnt_q == '0) begin
									err_d = 1'b1;
								end else begin
									cnt_d = cnt_q - 1'b1;
								end
							end
							smalu_pkg::CMD_INV, smalu_pkg::CMD_DUP: begin
								if (cnt_q == '0) begin
									err_d = 1'b1;
								end else begin
									state_d = smalu_pkg::ST_RD1;
								end
							end
							default: begin
								if (cnt_q < CntW'(2)) begin
									err_d = 1'b1;
								end else begin
									state_d = smalu_pkg::ST_RD1;
								end
							end
						endcase
					end
				end
			end
			smalu_pkg::ST_RD1: state_d = smalu_pkg::ST_RD2;
			smalu_pkg::ST_RD2: state_d = smalu_pkg::ST_EXEC;
			smalu_pkg::ST_EXEC: begin
				case (smalu_pkg::cmd_t'(cmd_q))
					smalu_pkg::CMD_DUP: begin
						if (full) begin
							err_d = 1'b1;
							state_d = smalu_pkg::ST_IDLE;
						end else begin
							state_d = smalu_pkg::ST_WR;
						end
					end
					smalu_pkg::CMD_MUL: state_d = smalu_pkg::ST_MUL;
					smalu_pkg::CMD_DIV, smalu_pkg::CMD_MOD: begin
						if (sts.div_zero) begin
							err_d = 1'b1;
							state_d = smalu_pkg::ST_IDLE;
						end else begin
							state_d = smalu_pkg::ST_DIV;
						end
					end
					default: state_d = smalu_pkg::ST_WR;
				endcase
			end
			smalu_pkg::ST_MUL: state_d = smalu_pkg::ST_WR;
			smalu_pkg::ST_DIV: if (sts.div_done) state_d = smalu_pkg::ST_WR;
			smalu_pkg::ST_WR: begin
				state_d = smalu_pkg::ST_IDLE;
				case (smalu_pkg::cmd_t'(cmd_q))
					smalu_pkg::CMD_INV: ;
					smalu_pkg::CMD_DUP: cnt_d = cnt_q + 1'b1;
					smalu_pkg::CMD_SWP: state_d = smalu_pkg::ST_WR2;
					default: begin
						if (res_big) begin
							err_d = 1'b1;
						end else begin
							cnt_d = cnt_q - 1'b1;
						end
					end
				endcase
			end
			smalu_pkg::ST_WR2: state_d = smalu_pkg::ST_IDLE;
			smalu_pkg::ST_OUT: begin
				if (out_ready) begin
					cnt_d = '0;
					err_d = 1'b0;
					state_d = smalu_pkg::ST_IDLE;
				end
			end
			default: state_d = smalu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == smalu_pkg::ST_IDLE);
		out_valid = (state_q == smalu_pkg::ST_OUT);
		ctl = '0;
		ctl.wr = smalu_pkg::WR_NONE;
		case (state_q)
			smalu_pkg::ST_IDLE: begin
				ctl.load = acc;
				if (acc && !err_q && !opnd_big) begin
					if (in_cmd == smalu_pkg::CMD_START) ctl.wr = smalu_pkg::WR_PUSH_OPND;
					if (in_cmd == smalu_pkg::CMD_NUM && !full) ctl.wr = smalu_pkg::WR_PUSH_OPND;
				end
			end
			smalu_pkg::ST_RD1: begin
				ctl.rd_top = 1'b1;
			end
			smalu_pkg::ST_RD2: begin
				ctl.rd_sec = 1'b1;
				ctl.cap_top = 1'b1;
			end
			smalu_pkg::ST_EXEC: begin
				ctl.cap_sec = 1'b1;
				ctl.mul_go = (cmd_q == smalu_pkg::CMD_MUL);
				ctl.div_go = (cmd_q == smalu_pkg::CMD_DIV) || (cmd_q == smalu_pkg::CMD_MOD);
			end
			smalu_pkg::ST_DIV: ctl.div_step = 1'b1;
			smalu_pkg::ST_WR: begin
				case (smalu_pkg::cmd_t'(cmd_q))
					smalu_pkg::CMD_INV: ctl.wr = smalu_pkg::WR_RES_TOP;
					smalu_pkg::CMD_DUP: ctl.wr = smalu_pkg::WR_PUSH_TOP;
					smalu_pkg::CMD_SWP: ctl.wr = smalu_pkg::WR_A_TOP;
					default: if (!res_big) ctl.wr = smalu_pkg::WR_RES_BELOW;
				endcase
			end
			smalu_pkg::ST_WR2: ctl.wr = smalu_pkg::WR_RES_BELOW;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smalu_pkg::ST_IDLE;
			cnt_q <= '0;
			err_q <= 1'b0;
			oerr_q <= 1'b0;
			cmd_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			err_q <= err_d;
			oerr_q <= oerr_d;
			if (acc) cmd_q <= in_cmd;
		end
	end
endmodule

### rtl/smalu_dp.sv
// Datapath: stack memory, operand registers, multiplier and radix-2 divider
module smalu_dp #(
	parameter int unsigned CntW = 11,
	parameter int unsigned Depth = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  smalu_pkg::ctl_t        ctl,
	input  logic [CntW-1:0]        count,
	input  logic [3:0]             in_cmd,
	input  logic signed [30:0]     in_operand,
	output logic                   opnd_big,
	output smalu_pkg::sts_t        sts,
	output logic                   res_big,
	output logic signed [30:0]     bottom
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	logic signed [30:0] mem [Depth];
	logic signed [30:0] rd_q, top_q, sec_q, bot_q;
	logic [3:0] cmd_q;
	logic signed [61:0] prod_q;
	logic signed [62:0] res;
	logic [30:0] quo_q, rem_q, dvs_q, dvd_q;
	logic [4:0] dcnt_q;
	logic qneg_q, rneg_q, busy_q;
	logic [31:0] trial;
	logic [30:0] rem_sh;
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic signed [30:0] wdata;
	logic [CntW-1:0] cm1, cm2;

	assign cm1 = count - 1'b1;
	assign cm2 = count - CntW'(2);
	assign opnd_big = (in_operand > smalu_pkg::MagLimit) || (in_operand < -smalu_pkg::MagLimit);
	assign sts = {busy_q && (dcnt_q == '0), top_q == '0};
	assign bottom = bot_q;

	always_comb begin
		case (smalu_pkg::cmd_t'(cmd_q))
			smalu_pkg::CMD_INV: res = -63'(top_q);
			smalu_pkg::CMD_ADD: res = 63'(sec_q) + 63'(top_q);
			smalu_pkg::CMD_SUB: res = 63'(sec_q) - 63'(top_q);
			smalu_pkg::CMD_MUL: res = 63'(prod_q);
			smalu_pkg::CMD_DIV: res = qneg_q ? -63'(signed'({1'b0, quo_q})) : 63'(signed'({1'b0, quo_q}));
			smalu_pkg::CMD_MOD: res = rneg_q ? -63'(signed'({1'b0, rem_q})) : 63'(signed'({1'b0, rem_q}));
			default: res = 63'(top_q);
		endcase
		res_big = (res > 63'(smalu_pkg::MagLimit)) || (res < -63'(smalu_pkg::MagLimit));
	end

	always_comb begin
		we = 1'b1;
		waddr = '0;
		wdata = top_q;
		case (ctl.wr)
			smalu_pkg::WR_PUSH_OPND: begin
				waddr = (in_cmd == smalu_pkg::CMD_START) ? '0 : AW'(count);
				wdata = in_operand;
			end
			smalu_pkg::WR_RES_TOP: begin
				waddr = AW'(cm1);
				wdata = res[30:0];
			end
			smalu_pkg::WR_RES_BELOW: begin
				waddr = AW'(cm2);
				wdata = (cmd_q == smalu_pkg::CMD_SWP) ? top_q : res[30:0];
			end
			smalu_pkg::WR_A_TOP: begin
				waddr = AW'(cm1);
				wdata = sec_q;
			end
			smalu_pkg::WR_PUSH_TOP: begin
				waddr = AW'(count);
				wdata = top_q;
			end
			default: we = 1'b0;
		endcase
		raddr = ctl.rd_sec ? AW'(cm2) : AW'(cm1);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign rem_sh = {rem_q[29:0], dvd_q[30]};
	assign trial = {1'b0, rem_sh} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dcnt_q <= '0;
			cmd_q <= '0;
		end else begin
			if (ctl.load) cmd_q <= in_cmd;
			if (ctl.div_go) begin
				busy_q <= 1'b1;
				dcnt_q <= 5'd31;
			end else if (ctl.div_step) begin
				if (dcnt_q == '0) busy_q <= 1'b0;
				else dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap_top) top_q <= rd_q;
		if (ctl.cap_sec) sec_q <= rd_q;
		if (we && waddr == '0) bot_q <= wdata;
		if (ctl.mul_go) prod_q <= 62'(rd_q) * 62'(top_q);
		if (ctl.div_go) begin
			dvd_q <= rd_q[30] ? 31'(-rd_q) : rd_q;
			dvs_q <= top_q[30] ? 31'(-top_q) : top_q;
			qneg_q <= rd_q[30] ^ top_q[30];
			rneg_q <= rd_q[30];
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctl.div_step && dcnt_q != '0) begin
			dvd_q <= {dvd_q[29:0], 1'b0};
			if (!trial[31]) begin
				rem_q <= trial[30:0];
				quo_q <= {quo_q[29:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[29:0], 1'b0};
			end
		end
	end
endmodule

### rtl/stack_machine_alu_top.sv
// Push, pop and start finish in IDLE; inv, dup, add, sub run RD1, RD2, EXEC and WR;
// swp adds WR2, mul adds MUL, and DIV/MOD add DIV, one quotient bit per cycle.
// END presents its result the next cycle and holds it until taken.
// One instruction at a time; a new request is taken only when the block is idle.
// Asynchronous active-low reset empties the stack and clears the error flag.
// Top level of the stack calculator
module stack_machine_alu_top #(
	parameter int unsigned STACK_DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	smalu_in_if.sink    in_ch,
	smalu_out_if.source out_ch
);
	localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
	smalu_pkg::ctl_t ctl;
	smalu_pkg::sts_t sts;
	logic [CntW-1:0] count;
	logic opnd_big, res_big, oerr;
	logic signed [30:0] bottom;

	smalu_ctrl #(.CntW(CntW), .Depth(STACK_DEPTH)) u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
		.opnd_big, .sts, .res_big, .ctl, .count,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_err(oerr)
	);

	smalu_dp #(.CntW(CntW), .Depth(STACK_DEPTH)) u_dp (
		.clk, .arst_n, .ctl, .count,
		.in_cmd(in_ch.cmd), .in_operand(in_ch.operand),
		.opnd_big, .sts, .res_big, .bottom
	);

	assign out_ch.error = oerr;
	assign out_ch.value = oerr ? '0 : bottom;
endmodule

### rtl/smalu_chk.sv
// Port-level checker for the stack calculator, bound to the top level
module smalu_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [3:0] in_cmd,
	input logic out_valid,
	input logic out_ready,
	input logic signed [30:0] out_value,
	input logic out_error
);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_value == '0) else $error("error result with nonzero value");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken while result pending");
	a_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == smalu_pkg::CMD_END |=> out_valid)
		else $error("END without result");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_error))
		else $error("result dropped");
endmodule

bind stack_machine_alu_top smalu_chk u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_value(out_ch.value), .out_error(out_ch.error)
);
